### src/pem_pkg.sv
// Package: request/result types and fixed field widths for prediction_error_metrics.
`timescale 1ns / 1ps
`default_nettype none
package pem_pkg;

  localparam int FIELD_BITS = 16;
  localparam int MSE_BITS   = 40;
  localparam int VAR_BITS   = 38;
  localparam int NERR_BITS  = 32;
  localparam int CNT_BITS   = 13;
  localparam int QUO_BITS   = 40;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] expected_value;
    logic signed [FIELD_BITS-1:0] actual_value;
    logic                         last_item;
  } pem_req_t;

  typedef struct packed {
    logic [MSE_BITS-1:0]  mean_sq_error;
    logic [VAR_BITS-1:0]  actual_variance;
    logic [NERR_BITS-1:0] normalized_error;
    logic                 zero_variance;
    logic [CNT_BITS-1:0]  pair_count;
  } pem_res_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } pem_div_stat_t;

endpackage
`default_nettype wire

### src/pem_mul.sv
// Shared registered multiplier for squares, products and the normaliser terms.
`timescale 1ns / 1ps
`default_nettype none
module pem_mul #(
  parameter int A_BITS = 44,
  parameter int B_BITS = 28
) (
  input  wire logic                     clk,
  input  wire logic [A_BITS-1:0]        a,
  input  wire logic [B_BITS-1:0]        b,
  output logic      [A_BITS+B_BITS-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

### src/pem_div.sv
// Shared restoring divider, one quotient bit per cycle, with quotient overflow flag.
`timescale 1ns / 1ps
`default_nettype none
module pem_div #(
  parameter int NUM_BITS = 73,
  parameter int DEN_BITS = 56
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [NUM_BITS-1:0]            num,
  input  wire logic [DEN_BITS-1:0]            den,
  output logic      [pem_pkg::QUO_BITS-1:0]   quo,
  output pem_pkg::pem_div_stat_t              stat
);
  import pem_pkg::*;

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] dvd;
  logic [DEN_BITS-1:0] dsr;
  logic [DEN_BITS-1:0] rem;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                done;
  logic                ovf;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem, dvd[NUM_BITS-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_BITS);
        dvd  <= num;
        dsr  <= den;
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        dvd <= dvd << 1;
        rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        quo <= {quo[QUO_BITS-2:0], fits};
        ovf <= ovf | quo[QUO_BITS-1];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done, ovf: ovf};

endmodule
`default_nettype wire

### src/prediction_error_metrics.sv
// Top level: normalised mean square error over a run of expected/actual pairs.
//
//   channel   ports                          carries
//   request   req_valid, req_ready, req_data  pem_req_t: expected, actual, last flag
//   result    res_valid, res_ready, res_data  pem_res_t: MSE, variance, NMSE, flag, count
//
// A pair steps through accept, S_SQD, S_SQA and S_ACC: two squares through the one shared multiplier.
// The final pair adds the multiplier steps S_NSQ, S_SS, S_SEN and S_NN and up to three divisions
// on the serial divider (73-bit dividend at default parameters); zero variance skips the third.
// Synchronous reset clears the sums, the count and all control state.
// A result waiting in the output register does not stop new requests; only the
// final pair of the next run holds until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
module prediction_error_metrics #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire pem_pkg::pem_req_t req_data,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output pem_pkg::pem_res_t      res_data
);
  import pem_pkg::*;

  localparam int SW   = SAMPLE_BITS;
  localparam int LW   = $clog2(MAX_PAIRS);
  localparam int NW   = $clog2(MAX_PAIRS + 1);
  localparam int SEW  = 2 * SW + LW;
  localparam int SUMW = SW + LW + 1;
  localparam int MAGW = SW + LW;
  localparam int SQW  = 2 * SW + LW - 1;
  localparam int DENW = NW + SQW;
  localparam int NUMW = SEW + NW;
  localparam int NNW  = 2 * NW;
  localparam int MBW  = MAGW;
  localparam int PW   = SEW + MBW;
  localparam int DVW  = NUMW + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_SQD, S_SQA, S_ACC, S_NSQ, S_SS, S_SEN, S_NN,
    S_DMSE, S_WMSE, S_WVAR, S_WNE, S_FIN
  } state_t;

  state_t state;

  logic [SEW-1:0]         se;
  logic signed [SUMW-1:0] ssum;
  logic [SQW-1:0]         sq;
  logic [NW-1:0]          n;
  logic [SW-1:0]          dmag;
  logic [SW-1:0]          amag;
  logic                   last_r;
  logic [DENW-1:0]        nsq;
  logic [DENW-1:0]        var_den;
  logic [NUMW-1:0]        ratio_num;
  logic [NNW-1:0]         nn;
  logic [MSE_BITS-1:0]    mse_r;
  logic [VAR_BITS-1:0]    var_r;
  logic [NERR_BITS-1:0]   nerr_r;
  logic                   zero_r;

  logic [SW-1:0]          exp_s;
  logic [SW-1:0]          act_s;
  logic signed [SW:0]     dd;
  logic signed [SW:0]     dneg;
  logic signed [SW:0]     aext;
  logic signed [SW:0]     aneg;
  logic signed [SUMW-1:0] sneg;
  logic [MAGW-1:0]        smag;
  logic [NW-1:0]          n_inc;
  logic                   req_fire;

  logic [SEW-1:0]         mul_a;
  logic [MBW-1:0]         mul_b;
  logic [PW-1:0]          prod;

  logic                   div_start;
  logic [DVW-1:0]         div_num;
  logic [DENW-1:0]        div_den;
  logic [QUO_BITS-1:0]    quo;
  pem_div_stat_t          div_stat;
  logic                   ne_sat;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  always_comb begin
    exp_s = SW'($unsigned(req_data.expected_value));
    act_s = SW'($unsigned(req_data.actual_value));
    aext  = $signed({act_s[SW-1], act_s});
    dd    = $signed({exp_s[SW-1], exp_s}) - aext;
    dneg  = -dd;
    aneg  = -aext;
    sneg  = -ssum;
    smag  = ssum[SUMW-1] ? sneg[MAGW-1:0] : ssum[MAGW-1:0];
    n_inc = n + 1'b1;
    ne_sat = div_stat.ovf || (quo[QUO_BITS-1:NERR_BITS] != '0);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQD: begin
        mul_a = SEW'(dmag);
        mul_b = MBW'(dmag);
      end
      S_SQA: begin
        mul_a = SEW'(amag);
        mul_b = MBW'(amag);
      end
      S_NSQ: begin
        mul_a = SEW'(sq);
        mul_b = MBW'(n);
      end
      S_SS: begin
        mul_a = SEW'(smag);
        mul_b = smag;
      end
      S_SEN: begin
        mul_a = se;
        mul_b = MBW'(n);
      end
      S_NN: begin
        mul_a = SEW'(n);
        mul_b = MBW'(n);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_DMSE: begin
        div_start = 1'b1;
        div_num   = DVW'({se, 8'b0});
        div_den   = DENW'(n);
      end
      S_WMSE: begin
        div_start = div_stat.done;
        div_num   = DVW'({var_den, 8'b0});
        div_den   = DENW'(nn);
      end
      S_WVAR: begin
        div_start = div_stat.done && (var_den != '0);
        div_num   = {ratio_num, 16'b0};
        div_den   = var_den;
      end
      default: begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
      end
    endcase
  end

  pem_mul #(
    .A_BITS (SEW),
    .B_BITS (MBW)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  pem_div #(
    .NUM_BITS (DVW),
    .DEN_BITS (DENW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      se        <= '0;
      ssum      <= '0;
      sq        <= '0;
      n         <= '0;
      last_r    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_FIN && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            dmag   <= dd[SW] ? dneg[SW-1:0] : dd[SW-1:0];
            amag   <= aext[SW] ? aneg[SW-1:0] : aext[SW-1:0];
            ssum   <= ssum + SUMW'(aext);
            n      <= n_inc;
            last_r <= req_data.last_item || (n_inc == NW'(MAX_PAIRS));
            state  <= S_SQD;
          end
        end
        S_SQD: begin
          state <= S_SQA;
        end
        S_SQA: begin
          se    <= se + SEW'(prod);
          state <= S_ACC;
        end
        S_ACC: begin
          sq    <= sq + SQW'(prod);
          state <= last_r ? S_NSQ : S_IDLE;
        end
        S_NSQ: begin
          state <= S_SS;
        end
        S_SS: begin
          nsq   <= DENW'(prod);
          state <= S_SEN;
        end
        S_SEN: begin
          var_den <= nsq - DENW'(prod);
          state   <= S_NN;
        end
        S_NN: begin
          ratio_num <= NUMW'(prod);
          state     <= S_DMSE;
        end
        S_DMSE: begin
          nn    <= NNW'(prod);
          state <= S_WMSE;
        end
        S_WMSE: begin
          if (div_stat.done) begin
            mse_r <= quo[MSE_BITS-1:0];
            state <= S_WVAR;
          end
        end
        S_WVAR: begin
          if (div_stat.done) begin
            var_r <= quo[VAR_BITS-1:0];
            if (var_den == '0) begin
              nerr_r <= '1;
              zero_r <= 1'b1;
              state  <= S_FIN;
            end else begin
              zero_r <= 1'b0;
              state  <= S_WNE;
            end
          end
        end
        S_WNE: begin
          if (div_stat.done) begin
            nerr_r <= ne_sat ? '1 : quo[NERR_BITS-1:0];
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || res_ready) begin
            res_data.mean_sq_error    <= mse_r;
            res_data.actual_variance  <= var_r;
            res_data.normalized_error <= nerr_r;
            res_data.zero_variance    <= zero_r;
            res_data.pair_count       <= CNT_BITS'(n);
            se                        <= '0;
            ssum                      <= '0;
            sq                        <= '0;
            n                         <= '0;
            last_r                    <= 1'b0;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= NW'(MAX_PAIRS))
    else $error("pair count beyond limit");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("request taken while previous pair in flight");

  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.zero_variance) |-> (res_data.normalized_error == '1))
    else $error("zero variance without saturated ratio");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

### bench/tb_prediction_error_metrics.sv
// Testbench for prediction_error_metrics: directed table, then random runs checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_prediction_error_metrics;
  import pem_pkg::*;

  localparam int RUN_LIMIT    = 4096;
  localparam int RANDOM_PAIRS = 830;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 400;

  typedef enum int {
    STYLE_FULL,
    STYLE_TINY,
    STYLE_EDGES,
    STYLE_MATCH,
    STYLE_FLAT,
    STYLE_NEAR
  } pair_style_t;

  typedef struct {
    pem_req_t req;
    bit       typed;
    pem_res_t res;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  pem_req_t req_data = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  pem_res_t res_data;

  prediction_error_metrics dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned err_sq_acc = 0;
  longint unsigned act_sq_acc = 0;
  longint unsigned pair_tally = 0;
  longint          act_acc    = 0;

  pem_res_t nmse_due[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       cycles = 0;
  bit       calm = 1'b0;

  task automatic report(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit fold_pair(input pem_req_t p, output pem_res_t r);
    longint          ev, av, dv;
    longint unsigned n, mag, den, num;
    logic [111:0]    ratio;
    r = '0;
    ev = longint'($signed(p.expected_value));
    av = longint'($signed(p.actual_value));
    dv = ev - av;
    err_sq_acc += longint'(dv * dv);
    act_acc    += av;
    act_sq_acc += longint'(av * av);
    pair_tally++;
    if (!p.last_item && pair_tally < RUN_LIMIT) return 1'b0;
    n   = pair_tally;
    mag = (act_acc < 0) ? longint'(-act_acc) : longint'(act_acc);
    den = n * act_sq_acc - mag * mag;
    num = err_sq_acc * n;
    r.mean_sq_error   = MSE_BITS'((err_sq_acc << 8) / n);
    r.actual_variance = VAR_BITS'((den << 8) / (n * n));
    r.zero_variance   = (den == 0);
    if (den == 0) begin
      r.normalized_error = '1;
    end else begin
      ratio = {32'd0, num, 16'd0} / {48'd0, den};
      r.normalized_error = (ratio > 112'hFFFF_FFFF) ? '1 : ratio[31:0];
    end
    r.pair_count = CNT_BITS'(n);
    err_sq_acc = 0;
    act_sq_acc = 0;
    pair_tally = 0;
    act_acc    = 0;
    return 1'b1;
  endfunction

  function automatic int idle_cycles();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_pair(input pem_req_t item, input bit typed = 1'b0,
                           input pem_res_t typed_res = '0);
    int       gap;
    pem_res_t r;
    gap = idle_cycles();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (fold_pair(item, r)) nmse_due = {nmse_due, (typed ? typed_res : r)};
  endtask

  task automatic add_row(input int e, input int a, input bit last, input bit typed = 1'b0,
                         input pem_res_t res = '0);
    dir_row_t row;
    row.req.expected_value = 16'(e);
    row.req.actual_value   = 16'(a);
    row.req.last_item      = last;
    row.typed = typed;
    row.res   = res;
    dir_rows = {dir_rows, row};
  endtask

  function automatic pem_req_t pick_pair(input pair_style_t style, input logic [15:0] held_a,
                                         input bit last);
    pem_req_t p;
    p.last_item = last;
    p.expected_value = 16'($urandom);
    p.actual_value   = 16'($urandom);
    case (style)
      STYLE_TINY: begin
        p.expected_value = 16'($urandom_range(0, 16) - 8);
        p.actual_value   = 16'($urandom_range(0, 16) - 8);
      end
      STYLE_EDGES: begin
        case ($urandom_range(0, 3))
          0: p.expected_value = 16'h8000;
          1: p.expected_value = 16'h7FFF;
          2: p.expected_value = 16'hFFFF;
          default: p.expected_value = 16'h0000;
        endcase
        case ($urandom_range(0, 3))
          0: p.actual_value = 16'h8000;
          1: p.actual_value = 16'h7FFF;
          2: p.actual_value = 16'hFFFF;
          default: p.actual_value = 16'h0000;
        endcase
      end
      STYLE_MATCH: p.expected_value = p.actual_value;
      STYLE_FLAT:  p.actual_value = held_a;
      STYLE_NEAR:  p.expected_value = p.actual_value + 16'($urandom_range(0, 64) - 32);
      default: ;
    endcase
    return p;
  endfunction

  task automatic drain();
    while (nmse_due.size() != 0) @(posedge clk);
  endtask

  // result side
  initial begin : result_sink
    int stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pem_res_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (nmse_due.size() == 0) begin
        report($sformatf("result %0d arrived with none outstanding", results_seen));
      end else begin
        want = nmse_due.pop_front();
        if (res_data.mean_sq_error !== want.mean_sq_error)
          report($sformatf("result %0d mean_sq_error %0d, want %0d", results_seen,
                           res_data.mean_sq_error, want.mean_sq_error));
        if (res_data.actual_variance !== want.actual_variance)
          report($sformatf("result %0d actual_variance %0d, want %0d", results_seen,
                           res_data.actual_variance, want.actual_variance));
        if (res_data.normalized_error !== want.normalized_error)
          report($sformatf("result %0d normalized_error %0h, want %0h", results_seen,
                           res_data.normalized_error, want.normalized_error));
        if (res_data.zero_variance !== want.zero_variance)
          report($sformatf("result %0d zero_variance %0b, want %0b", results_seen,
                           res_data.zero_variance, want.zero_variance));
        if (res_data.pair_count !== want.pair_count)
          report($sformatf("result %0d pair_count %0d, want %0d", results_seen,
                           res_data.pair_count, want.pair_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          sent;
    int          runs;
    int          len;
    pair_style_t style;
    logic [15:0] held_a;

    // zero variance, single pairs at the extremes
    add_row(0, 0, 1'b1, 1'b1, pem_res_t'{40'd0, 38'd0, 32'hFFFF_FFFF, 1'b1, 13'd1});
    add_row(32767, -32768, 1'b1, 1'b1,
            pem_res_t'{40'hFF_FE00_0100, 38'd0, 32'hFFFF_FFFF, 1'b1, 13'd1});
    add_row(-32768, 32767, 1'b1, 1'b1,
            pem_res_t'{40'hFF_FE00_0100, 38'd0, 32'hFFFF_FFFF, 1'b1, 13'd1});
    // perfect prediction: ratio zero
    add_row(5, 5, 1'b0);
    add_row(-7, -7, 1'b1, 1'b1, pem_res_t'{40'd0, 38'd9216, 32'd0, 1'b0, 13'd2});
    // ratio exactly one
    add_row(0, 3, 1'b0);
    add_row(0, -3, 1'b1, 1'b1, pem_res_t'{40'd2304, 38'd2304, 32'h0001_0000, 1'b0, 13'd2});
    // widest actual spread
    add_row(0, -32768, 1'b0);
    add_row(0, 32767, 1'b1);
    // ratio too large: tiny variance, huge error
    add_row(32767, 0, 1'b0);
    add_row(-32768, 1, 1'b1);
    // flat actual with nonzero error
    add_row(100, -32768, 1'b0);
    add_row(-100, -32768, 1'b0);
    add_row(0, -32768, 1'b1);
    // all-ones and extreme-value patterns
    add_row(-1, 1, 1'b0);
    add_row(1, -1, 1'b0);
    add_row(-1, -1, 1'b1);
    add_row(32767, 32767, 1'b0);
    add_row(-32768, -1, 1'b0);
    add_row(-1, -32768, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_pair(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    req_valid <= 1'b0;
    drain();

    sent = 0;
    runs = 0;
    while (sent < RANDOM_PAIRS) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 12);
      style  = pair_style_t'($urandom_range(0, 5));
      held_a = 16'($urandom);
      calm   = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len; k++) begin
        send_pair(pick_pair(style, held_a, k == len - 1));
      end
      sent += len;
      runs++;
      if (runs % 8 == 0) begin
        req_valid <= 1'b0;
        drain();
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && nmse_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### prediction_error_metrics.f
src/pem_pkg.sv
src/pem_mul.sv
src/pem_div.sv
src/prediction_error_metrics.sv
bench/tb_prediction_error_metrics.sv
